// File: sv/two_button_hold_classifier_core_defines.svh
// Assertion macros for the two-button hold classifier checker
`ifndef TWO_BUTTON_HOLD_CLASSIFIER_CORE_DEFINES_SVH
`define TWO_BUTTON_HOLD_CLASSIFIER_CORE_DEFINES_SVH

// Check a condition on every presented result item
`define TBHC_ASSERT_OUT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (o_out_valid |-> (cond))) else $error(msg);

// Check that a signal holds while a result item is stalled
`define TBHC_ASSERT_HOLD(lbl, sig, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (o_out_valid && !i_out_ready |=> $stable(sig))) else $error(msg);

`endif

// File: sv/tbhc_pkg.sv
// Shared types and constants of the two-button hold classifier
`default_nettype none
package tbhc_pkg;

    localparam int unsigned TimeW = 32;
    localparam int unsigned CfgW  = 24;
    localparam int unsigned CfgIdxW = 3;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_GRACE        = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_UPDATE_WARN  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_UPDATE_HOLD  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_RESET_WARN   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_RESET_HOLD   = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_BLINK_PERIOD = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_SESS_TIMEOUT = 3'd6;

    // warning stage codes
    localparam logic [1:0] WARN_NONE   = 2'd0;
    localparam logic [1:0] WARN_UPDATE = 2'd1;
    localparam logic [1:0] WARN_RESET  = 2'd2;

    typedef struct packed {
        logic [15:0] grace_ms;
        logic [15:0] update_warn_ms;
        logic [15:0] update_hold_ms;
        logic [15:0] reset_warn_ms;
        logic [15:0] factory_hold_ms;
        logic [15:0] blink_period_ms;
        logic [23:0] session_timeout_ms;
    } t_cfg;

    typedef struct packed {
        logic             button_a_pressed;
        logic             button_b_pressed;
        logic [TimeW-1:0] time_ms;
        logic             session_started;
    } t_item;

    typedef struct packed {
        logic [1:0] warn_stage;
        logic       led_write;
        logic       led_level;
        logic       led_refresh;
        logic       update_reboot_request;
        logic       factory_reset_request;
        logic       session_stop_request;
        logic       hold_active;
        logic       session_active;
    } t_result;

    typedef struct packed {
        logic             holding;
        logic [TimeW-1:0] hold_start_time;
        logic             blink_level;
        logic [TimeW-1:0] last_toggle_time;
        logic             session_on;
        logic [TimeW-1:0] session_start_time;
    } t_state;

endpackage
`default_nettype wire

// File: sv/tbhc_cfg.sv
// Configuration register file of the two-button hold classifier
`default_nettype none
module tbhc_cfg (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [tbhc_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [tbhc_pkg::CfgW-1:0]       i_cfg_data,
    output tbhc_pkg::t_cfg                       o_cfg
);
    import tbhc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grace_ms           <= 16'd5000;
            r_cfg.update_warn_ms     <= 16'd3000;
            r_cfg.update_hold_ms     <= 16'd5000;
            r_cfg.reset_warn_ms      <= 16'd7000;
            r_cfg.factory_hold_ms    <= 16'd10000;
            r_cfg.blink_period_ms    <= 16'd100;
            r_cfg.session_timeout_ms <= 24'd300000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GRACE:        r_cfg.grace_ms           <= i_cfg_data[15:0];
                CFG_UPDATE_WARN:  r_cfg.update_warn_ms     <= i_cfg_data[15:0];
                CFG_UPDATE_HOLD:  r_cfg.update_hold_ms     <= i_cfg_data[15:0];
                CFG_RESET_WARN:   r_cfg.reset_warn_ms      <= i_cfg_data[15:0];
                CFG_RESET_HOLD:   r_cfg.factory_hold_ms    <= i_cfg_data[15:0];
                CFG_BLINK_PERIOD: r_cfg.blink_period_ms    <= i_cfg_data[15:0];
                CFG_SESS_TIMEOUT: r_cfg.session_timeout_ms <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: sv/tbhc_step.sv
// Per-sample next-state and result logic of the two-button hold classifier
`default_nettype none
module tbhc_step (
    input  wire tbhc_pkg::t_cfg    i_cfg,
    input  wire tbhc_pkg::t_state  i_state,
    input  wire tbhc_pkg::t_item   i_item,
    output tbhc_pkg::t_state       o_state,
    output tbhc_pkg::t_result      o_result
);
    import tbhc_pkg::*;

    logic             both;
    logic [TimeW-1:0] now;
    logic             sess_on;
    logic [TimeW-1:0] sess_start;
    logic [TimeW-1:0] sess_elapsed;
    logic             timed_out;
    logic             in_grace;
    logic [TimeW-1:0] held_raw;
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] since_toggle;
    logic             blink_due;

    always_comb begin
        both = i_item.button_a_pressed & i_item.button_b_pressed;
        now  = i_item.time_ms;

        // session start restarts the timer, then check the timeout
        sess_on      = i_item.session_started | i_state.session_on;
        sess_start   = i_item.session_started ? now : i_state.session_start_time;
        sess_elapsed = now - sess_start;
        timed_out    = sess_on && (sess_elapsed >= {8'd0, i_cfg.session_timeout_ms});

        in_grace     = both && !(sess_on && !timed_out) && (now < {16'd0, i_cfg.grace_ms});
        held_raw     = now - i_state.hold_start_time;
        // a fresh hold starts at zero
        held         = i_state.holding ? held_raw : '0;
        since_toggle = now - i_state.last_toggle_time;
        blink_due    = since_toggle >= {16'd0, i_cfg.blink_period_ms};

        o_state                    = i_state;
        o_state.session_on         = sess_on & ~timed_out;
        o_state.session_start_time = sess_start;

        o_result                      = '0;
        o_result.warn_stage           = WARN_NONE;
        o_result.session_stop_request = timed_out;

        if (in_grace) begin
            // ignore the sample: hold state untouched
        end else if (!both) begin
            if (i_state.holding) begin
                o_state.holding      = 1'b0;
                o_result.led_refresh = 1'b1;
                o_result.update_reboot_request =
                    (held_raw >= {16'd0, i_cfg.update_hold_ms}) &&
                    (held_raw <  {16'd0, i_cfg.factory_hold_ms});
            end
        end else begin
            o_state.holding = 1'b1;
            if (!i_state.holding) begin
                o_state.hold_start_time = now;
            end
            if (held >= {16'd0, i_cfg.factory_hold_ms}) begin
                o_state.holding                = 1'b0;
                o_result.factory_reset_request = 1'b1;
            end else if (held >= {16'd0, i_cfg.reset_warn_ms} ||
                         held >= {16'd0, i_cfg.update_warn_ms}) begin
                o_result.warn_stage = (held >= {16'd0, i_cfg.reset_warn_ms}) ?
                                      WARN_RESET : WARN_UPDATE;
                if (blink_due) begin
                    o_state.last_toggle_time = now;
                    o_state.blink_level      = ~i_state.blink_level;
                    o_result.led_write       = 1'b1;
                end
            end
        end

        o_result.led_level      = o_state.blink_level;
        o_result.hold_active    = o_state.holding;
        o_result.session_active = o_state.session_on;
    end

endmodule
`default_nettype wire

// File: sv/two_button_hold_classifier_core.sv
// Top level of the two-button hold classifier: input register, step logic, result register
// Path: an item is held in the input register, then its result in the result register;
// a stalled result keeps the next item waiting in the input register.
// Throughput: one item per clock unless the output stalls; the step logic between the two
// registers is a few 32-bit subtracts and compares; the state registers update per item.
// Reset (synchronous, active low): pipeline empty, hold/blink/session state cleared,
// configuration registers back to their defaults.
`default_nettype none
module two_button_hold_classifier_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration write port
    input  wire logic                         i_cfg_we,
    input  wire logic [tbhc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [tbhc_pkg::CfgW-1:0]    i_cfg_data,
    // sample channel
    input  wire logic                         i_in_valid,
    output      logic                         o_in_ready,
    input  wire logic                         i_button_a_pressed,
    input  wire logic                         i_button_b_pressed,
    input  wire logic [tbhc_pkg::TimeW-1:0]   i_time_ms,
    input  wire logic                         i_session_started,
    // result channel
    output      logic                         o_out_valid,
    input  wire logic                         i_out_ready,
    output      logic [1:0]                   o_warn_stage,
    output      logic                         o_led_write,
    output      logic                         o_led_level,
    output      logic                         o_led_refresh,
    output      logic                         o_update_reboot_request,
    output      logic                         o_factory_reset_request,
    output      logic                         o_session_stop_request,
    output      logic                         o_hold_active,
    output      logic                         o_session_active
);
    import tbhc_pkg::*;

    t_cfg    cfg;
    t_state  r_state;
    t_state  n_state;
    t_result n_result;
    t_result r_result;
    t_item   r_item;
    logic    r_item_vld;
    logic    r_out_vld;
    logic    advance;

    tbhc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tbhc_step u_step (
        .i_cfg    (cfg),
        .i_state  (r_state),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // advance the held item whenever the result register is free or being emptied
    assign advance    = r_item_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_item_vld || advance;

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_state    <= '0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_item_vld <= 1'b1;
            end else if (advance) begin
                r_item_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item.button_a_pressed <= i_button_a_pressed;
            r_item.button_b_pressed <= i_button_b_pressed;
            r_item.time_ms          <= i_time_ms;
            r_item.session_started  <= i_session_started;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid             = r_out_vld;
    assign o_warn_stage            = r_result.warn_stage;
    assign o_led_write             = r_result.led_write;
    assign o_led_level             = r_result.led_level;
    assign o_led_refresh           = r_result.led_refresh;
    assign o_update_reboot_request = r_result.update_reboot_request;
    assign o_factory_reset_request = r_result.factory_reset_request;
    assign o_session_stop_request  = r_result.session_stop_request;
    assign o_hold_active           = r_result.hold_active;
    assign o_session_active        = r_result.session_active;

endmodule
`default_nettype wire

// File: sv/tbhc_checker.sv
// Port-level checker of the two-button hold classifier and its bind
`default_nettype none
`include "two_button_hold_classifier_core_defines.svh"
module tbhc_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [1:0] o_warn_stage,
    input wire logic       o_led_write,
    input wire logic       o_led_refresh,
    input wire logic       o_update_reboot_request,
    input wire logic       o_factory_reset_request,
    input wire logic       o_hold_active
);
    import tbhc_pkg::*;

    // a factory reset drops the hold
    `TBHC_ASSERT_OUT(a_reset_ends_hold, !o_factory_reset_request || !o_hold_active, "factory reset with hold active")
    // an update reboot only comes with a release
    `TBHC_ASSERT_OUT(a_reboot_on_release, !o_update_reboot_request || o_led_refresh, "update reboot without release")
    // the LED is only driven during a warning
    `TBHC_ASSERT_OUT(a_write_in_warning, !o_led_write || o_warn_stage != WARN_NONE, "LED write outside a warning")
    // a stalled item stays presented, unchanged
    `TBHC_ASSERT_HOLD(a_valid_holds, o_out_valid, "result item dropped while stalled")
    `TBHC_ASSERT_HOLD(a_warn_holds, o_warn_stage, "warning stage changed while stalled")

endmodule

bind two_button_hold_classifier_core tbhc_checker u_tbhc_checker (.*);
`default_nettype wire
